@@ hw/rtl/emm_pkg.sv @@
// Shared types, widths and coefficient tables for the element mass matrix block.
// No dependencies.
`default_nettype none
package emm_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MINOR_W    = PROD_W + 1;
    localparam int TERM_W     = DIFF_W + MINOR_W;
    localparam int DELTA_W    = TERM_W + 2;
    localparam int VALUE_W    = 51;
    localparam int COEF_W     = 32;
    localparam int CMAG_W     = 28;
    localparam int LO_W       = 26;
    localparam int HI_W       = DELTA_W - LO_W;
    localparam int COEF_FRAC  = 30;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_TRI_P1  = 3'd0,
        KIND_TRI_P1B = 3'd1,
        KIND_TRI_P2  = 3'd2,
        KIND_TET_P1  = 3'd3,
        KIND_TET_P2  = 3'd4,
        KIND_TET_P1B = 3'd5
    } kind_t;

    typedef struct packed {
        logic [2:0]                 kind;
        logic signed [DELTA_W-1:0]  delta;
    } emm_item_t;

    function automatic logic [3:0] node_count(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            KIND_TRI_P1:  n = 4'd3;
            KIND_TRI_P1B: n = 4'd4;
            KIND_TRI_P2:  n = 4'd6;
            KIND_TET_P1:  n = 4'd4;
            KIND_TET_P2:  n = 4'd10;
            KIND_TET_P1B: n = 4'd5;
            default:      n = 4'd3;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] edge_lo(input logic [2:0] e);
        logic [3:0] v;
        unique case (e)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd1;
            3'd2:    v = 4'd0;
            3'd3:    v = 4'd0;
            3'd4:    v = 4'd1;
            default: v = 4'd2;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] edge_hi(input logic [2:0] e);
        logic [3:0] v;
        unique case (e)
            3'd0:    v = 4'd1;
            3'd1:    v = 4'd2;
            3'd2:    v = 4'd2;
            default: v = 4'd3;
        endcase
        return v;
    endfunction

    function automatic logic edge_has(input logic [2:0] e, input logic [3:0] v);
        return (edge_lo(e) == v) || (edge_hi(e) == v);
    endfunction

    // Q1.30 coefficient of entry (r, c), r <= c
    function automatic logic signed [COEF_W-1:0] coef_q30(
        input logic [2:0] k, input logic [3:0] r, input logic [3:0] c);
        logic signed [COEF_W-1:0] q;
        logic [2:0] ec;
        logic [2:0] er;
        ec = 3'(c - 4'd4);
        er = 3'(r - 4'd4);
        q  = '0;
        unique case (k)
            KIND_TRI_P1: q = (r == c) ? 32'sd89478485 : 32'sd44739243;
            KIND_TRI_P1B: begin
                if (c == 4'd3) q = (r == 4'd3) ? 32'sd155309085 : 32'sd28760942;
                else           q = (r == c) ? 32'sd53047959 : 32'sd8308716;
            end
            KIND_TRI_P2: begin
                if (c < 4'd3)      q = (r == c) ? 32'sd17895697 : -32'sd2982616;
                else if (r < 4'd3) begin
                    if ((r == 4'd0 && c == 4'd4) || (r == 4'd1 && c == 4'd5) ||
                        (r == 4'd2 && c == 4'd3))
                        q = -32'sd11930465;
                    else
                        q = '0;
                end
                else               q = (r == c) ? 32'sd95443718 : 32'sd47721859;
            end
            KIND_TET_P1: q = (r == c) ? 32'sd17895697 : 32'sd8947849;
            KIND_TET_P2: begin
                if (c < 4'd4)      q = (r == c) ? 32'sd2556528 : 32'sd426088;
                else if (r < 4'd4) q = edge_has(ec, r) ? -32'sd1704352 : -32'sd2556528;
                else if (r == c)   q = 32'sd13634817;
                else if (edge_has(ec, edge_lo(er)) || edge_has(ec, edge_hi(er)))
                                   q = 32'sd6817408;
                else               q = 32'sd3408704;
            end
            KIND_TET_P1B: begin
                if (c == 4'd4) q = (r == 4'd4) ? 32'sd28206166 : 32'sd6583275;
                else           q = (r == c) ? 32'sd12841174 : 32'sd3893326;
            end
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/element_mass_matrix.sv @@
// Top level of the element mass matrix block: config register, front end, queue, back end.
// Depends on emm_pkg, emm_front, emm_queue, emm_back.
//
//  channel   dir  handshake             payload
//  s_        in   s_tvalid/s_tready     s_tdata: ax..dz, 16 bits each
//  m_        out  m_tvalid/m_tready     m_tdata: row, col, value; m_tlast
//  cfg_      in   cfg_valid/cfg_ready   cfg_data: element_kind
//
// One request in per cycle unless a full queue stalls the front end; the back end emits
// one entry per cycle while m_tready is not holding it, one for each upper-triangle entry
// that the entry walk visits (6 to 55). Reset clears kind and all valids; m_tready low stalls
// the back end, and the front end keeps taking requests until the four-deep queue fills.
`default_nettype none
module element_mass_matrix (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // ax,ay,az,bx,by_coord,bz,cx,cy,cz,dx,dy,dz
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // entry_row[3:0], entry_col[7:4], entry_value[58:8]
    output logic              m_tlast,   // last_entry
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_data   // element_kind
);
    logic [2:0] kind_reg;
    logic f_valid, f_ready, q_valid, q_pop;
    emm_pkg::emm_item_t f_item, q_item;
    logic [3:0] row, col;
    logic signed [emm_pkg::VALUE_W-1:0] value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) kind_reg <= 3'(emm_pkg::KIND_TRI_P1);
        else if (cfg_valid) kind_reg <= cfg_data;
    end

    emm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .kind(kind_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    emm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_pop(q_pop), .rd_item(q_item)
    );

    emm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_row(row), .m_col(col), .m_value(value), .m_last(m_tlast)
    );

    assign m_tdata = {5'd0, value, col, row};
endmodule
`default_nettype wire

@@ hw/rtl/emm_front.sv @@
// Front end: accepts coordinate requests and forms the determinant Delta in five stages.
// Depends on emm_pkg.
`default_nettype none
module emm_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [191:0]        in_data,
    input  wire logic [2:0]          kind,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output emm_pkg::emm_item_t       out_item
);
    localparam int DW = emm_pkg::DIFF_W;
    localparam int PW = emm_pkg::PROD_W;
    localparam int MW = emm_pkg::MINOR_W;
    localparam int TW = emm_pkg::TERM_W;
    localparam int XW = emm_pkg::DELTA_W;
    localparam int CB = emm_pkg::COORD_BITS;

    logic ce;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [2:0] k1_reg, k2_reg, k3_reg, k4_reg, k5_reg;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg, i_reg;
    logic signed [DW-1:0] a2_reg, b2_reg, c2_reg, a3_reg, b3_reg, c3_reg;
    logic signed [PW-1:0] pei_reg, pfh_reg, pdi_reg, pfg_reg, pdh_reg, peg_reg;
    logic signed [PW-1:0] pae_reg, pdb_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, d2_reg, d2b_reg;
    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [XW-1:0] delta_reg;
    logic signed [CB-1:0] x0, y0, z0;

    assign x0 = $signed(in_data[0*16 +: CB]);
    assign y0 = $signed(in_data[1*16 +: CB]);
    assign z0 = $signed(in_data[2*16 +: CB]);

    function automatic logic signed [DW-1:0] diff(input logic [CB-1:0] p,
                                                   input logic signed [CB-1:0] o);
        return DW'($signed(p)) - DW'(o);
    endfunction

    assign out_valid = v5_reg && (k5_reg <= 3'(emm_pkg::KIND_TET_P1B));
    assign ce        = !(out_valid && !out_ready);
    assign in_ready  = ce;
    assign out_item.kind  = k5_reg;
    assign out_item.delta = delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0; v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg;   v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k1_reg <= kind;
            a_reg  <= diff(in_data[3*16 +: CB], x0);
            b_reg  <= diff(in_data[4*16 +: CB], y0);
            c_reg  <= diff(in_data[5*16 +: CB], z0);
            d_reg  <= diff(in_data[6*16 +: CB], x0);
            e_reg  <= diff(in_data[7*16 +: CB], y0);
            f_reg  <= diff(in_data[8*16 +: CB], z0);
            g_reg  <= diff(in_data[9*16 +: CB], x0);
            h_reg  <= diff(in_data[10*16 +: CB], y0);
            i_reg  <= diff(in_data[11*16 +: CB], z0);

            k2_reg  <= k1_reg;
            a2_reg  <= a_reg; b2_reg <= b_reg; c2_reg <= c_reg;
            pei_reg <= e_reg * i_reg; pfh_reg <= f_reg * h_reg;
            pdi_reg <= d_reg * i_reg; pfg_reg <= f_reg * g_reg;
            pdh_reg <= d_reg * h_reg; peg_reg <= e_reg * g_reg;
            pae_reg <= a_reg * e_reg; pdb_reg <= d_reg * b_reg;

            k3_reg <= k2_reg;
            a3_reg <= a2_reg; b3_reg <= b2_reg; c3_reg <= c2_reg;
            m1_reg <= MW'(pei_reg) - MW'(pfh_reg);
            m2_reg <= MW'(pdi_reg) - MW'(pfg_reg);
            m3_reg <= MW'(pdh_reg) - MW'(peg_reg);
            d2_reg <= MW'(pae_reg) - MW'(pdb_reg);

            k4_reg  <= k3_reg;
            d2b_reg <= d2_reg;
            t1_reg  <= a3_reg * m1_reg;
            t2_reg  <= b3_reg * m2_reg;
            t3_reg  <= c3_reg * m3_reg;

            k5_reg <= k4_reg;
            if (k4_reg < 3'(emm_pkg::KIND_TET_P1))
                delta_reg <= XW'(d2b_reg);
            else
                delta_reg <= XW'(t1_reg) - XW'(t2_reg) + XW'(t3_reg);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/emm_queue.sv @@
// Short queue between the front and back ends, holding kind and Delta.
// Depends on emm_pkg.
`default_nettype none
module emm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire emm_pkg::emm_item_t wr_item,
    output logic                    rd_valid,
    input  wire logic               rd_pop,
    output emm_pkg::emm_item_t      rd_item
);
    emm_pkg::emm_item_t              mem_reg [emm_pkg::QDEPTH];
    logic [emm_pkg::QPTR_W-1:0]      wp_reg, rp_reg;
    logic [emm_pkg::QPTR_W:0]        cnt_reg, cnt_next;
    logic                            push, pop;

    assign wr_ready = cnt_reg != (emm_pkg::QPTR_W+1)'(emm_pkg::QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)      cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_item;
    end
endmodule
`default_nettype wire

@@ hw/rtl/emm_back.sv @@
// Back end: walks the upper triangle and scales Delta by each rounded coefficient.
// Depends on emm_pkg.
`default_nettype none
module emm_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_pop,
    input  wire emm_pkg::emm_item_t         q_item,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [3:0]                      m_row,
    output logic [3:0]                      m_col,
    output logic signed [emm_pkg::VALUE_W-1:0] m_value,
    output logic                            m_last
);
    localparam int XW = emm_pkg::DELTA_W;
    localparam int CW = emm_pkg::CMAG_W;
    localparam int LW = emm_pkg::LO_W;
    localparam int HW = emm_pkg::HI_W;
    localparam int VW = emm_pkg::VALUE_W;
    localparam int SW = HW + CW + LW + 2;

    logic bce, last_here, row_end;
    logic [3:0] r_reg, c_reg, n;
    logic signed [emm_pkg::COEF_W-1:0] coef;
    logic [XW-1:0] dmag;
    logic [emm_pkg::COEF_W-1:0] cabs;

    logic          v0_reg, va_reg, vb_reg, vo_reg;
    logic [3:0]    r0_reg, c0_reg, ra_reg, ca_reg, rb_reg, cb_reg, ro_reg, co_reg;
    logic          l0_reg, la_reg, lb_reg, lo_reg;
    logic          n0_reg, na_reg, nb_reg;
    logic [XW-1:0] mag0_reg;
    logic [CW-1:0] cm0_reg;
    logic [HW+CW-1:0] ph_reg;
    logic [LW+CW-1:0] pl_reg;
    logic [VW-1:0]    mb_reg;
    logic [VW-1:0]    val_reg;
    logic [SW-1:0]    sum;

    assign bce       = !vo_reg || m_ready;
    assign n         = emm_pkg::node_count(q_item.kind);
    assign row_end   = c_reg == n - 4'd1;
    assign last_here = row_end && (r_reg == n - 4'd1);
    assign q_pop     = bce && q_valid && last_here;
    assign coef      = emm_pkg::coef_q30(q_item.kind, r_reg, c_reg);
    assign dmag      = q_item.delta[XW-1] ? XW'(-q_item.delta) : XW'(q_item.delta);
    assign cabs      = coef[emm_pkg::COEF_W-1] ? 32'(-coef) : 32'(coef);
    assign sum       = (SW'(ph_reg) << LW) + SW'(pl_reg)
                     + (SW'(1) << (emm_pkg::COEF_FRAC - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg  <= '0;
            c_reg  <= '0;
            v0_reg <= 1'b0; va_reg <= 1'b0; vb_reg <= 1'b0; vo_reg <= 1'b0;
        end else if (bce) begin
            v0_reg <= q_valid;
            va_reg <= v0_reg;
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
            if (q_valid) begin
                if (last_here) begin
                    r_reg <= '0;
                    c_reg <= '0;
                end else if (row_end) begin
                    r_reg <= r_reg + 4'd1;
                    c_reg <= r_reg + 4'd1;
                end else begin
                    c_reg <= c_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bce) begin
            r0_reg   <= r_reg;  c0_reg <= c_reg;  l0_reg <= last_here;
            n0_reg   <= q_item.delta[XW-1] ^ coef[emm_pkg::COEF_W-1];
            mag0_reg <= dmag;
            cm0_reg  <= CW'(cabs);

            ra_reg <= r0_reg; ca_reg <= c0_reg; la_reg <= l0_reg; na_reg <= n0_reg;
            ph_reg <= mag0_reg[XW-1:LW] * cm0_reg;
            pl_reg <= mag0_reg[LW-1:0] * cm0_reg;

            rb_reg <= ra_reg; cb_reg <= ca_reg; lb_reg <= la_reg; nb_reg <= na_reg;
            mb_reg <= sum[emm_pkg::COEF_FRAC +: VW];

            ro_reg  <= rb_reg; co_reg <= cb_reg; lo_reg <= lb_reg;
            val_reg <= nb_reg ? VW'(-mb_reg) : mb_reg;
        end
    end

    assign m_valid = vo_reg;
    assign m_row   = ro_reg;
    assign m_col   = co_reg;
    assign m_value = $signed(val_reg);
    assign m_last  = lo_reg;
endmodule
`default_nettype wire
